// File: rtl/cter_pkg.sv
// ----------------------------------------------------------------------------
// cter_pkg
// Shared types and constants of the cyclic timed event replay block.
// ----------------------------------------------------------------------------
package cter_pkg;

   localparam int PATTERN_DEPTH = 64;
   localparam int MAX_PER_TICK  = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam int TIME_W   = 48;
   localparam int IDX_W    = $clog2(PATTERN_DEPTH);
   localparam int CNT_W    = $clog2(PATTERN_DEPTH + 1);
   localparam int NCNT_W   = $clog2(MAX_PER_TICK + 1);
   localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W = 3;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_BUS    = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   localparam logic [7:0] TIME_SOURCE = 8'h00;
   localparam logic [7:0] TIME_CODE   = 8'h10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SOURCE_ID = '0;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [TIME_W-1:0] entry_offset;
      logic [7:0]        event_source;
      logic [7:0]        event_code;
      logic [15:0]       word_high;
      logic [15:0]       word_mid;
      logic [15:0]       word_low;
   } req_type;

   typedef struct packed {
      logic [7:0]        out_source;
      logic [5:0]        entry_index;
      logic [TIME_W-1:0] event_time;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_SET_TIME,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_FLUSH
   } replay_state_type;

endpackage

// File: rtl/cter_cmd_queue.sv
// ----------------------------------------------------------------------------
// cter_cmd_queue
// Front end: accepts input items, drops the ones that do nothing and queues
// the rest as decoded commands for the replay engine.
// ----------------------------------------------------------------------------
module cter_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cter_pkg::req_type req_item,
   output logic              cmd_valid,
   output cter_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);

   cter_pkg::cmd_type                  entry_ff [cter_pkg::QUEUE_DEPTH];
   logic [cter_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cter_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cter_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               is_append, is_time, is_tick, wr_en, rd_en;
   cter_pkg::cmd_type                  decoded;

   always_comb begin
      is_append = req_item.cmd == cter_pkg::CMD_APPEND;
      is_time   = (req_item.cmd == cter_pkg::CMD_BUS) &&
                  (req_item.event_source == cter_pkg::TIME_SOURCE) &&
                  (req_item.event_code == cter_pkg::TIME_CODE);
      is_tick   = req_item.cmd == cter_pkg::CMD_TICK;
      if (is_append) begin
         decoded.op    = cter_pkg::OP_APPEND;
         decoded.value = req_item.entry_offset;
      end else if (is_time) begin
         decoded.op    = cter_pkg::OP_SET_TIME;
         decoded.value = {req_item.word_high, req_item.word_mid, req_item.word_low};
      end else begin
         decoded.op    = cter_pkg::OP_TICK;
         decoded.value = req_item.entry_offset;
      end
   end

   assign full      = count_ff == cter_pkg::QCNT_W'(cter_pkg::QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd_data  = entry_ff[rd_ptr_ff];

   // drop unused codes and foreign bus events right at the transfer
   assign wr_en = push && !full && (is_append || is_time || is_tick);
   assign rd_en = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == cter_pkg::QPTR_W'(cter_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == cter_pkg::QPTR_W'(cter_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/cter_rsp_queue.sv
// ----------------------------------------------------------------------------
// cter_rsp_queue
// Result queue between the replay engine and the result port.
// ----------------------------------------------------------------------------
module cter_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  cter_pkg::rsp_type wr_data,
   output logic              wr_full,
   output logic              empty,
   input  logic              pop,
   output cter_pkg::rsp_type rsp_item
);

   cter_pkg::rsp_type           entry_ff [cter_pkg::QUEUE_DEPTH];
   logic [cter_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cter_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cter_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        wr_en, rd_en;

   assign wr_full  = count_ff == cter_pkg::QCNT_W'(cter_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign rsp_item = entry_ff[rd_ptr_ff];
   assign wr_en    = wr_valid && !wr_full;
   assign rd_en    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == cter_pkg::QPTR_W'(cter_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == cter_pkg::QPTR_W'(cter_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/cter_replay.sv
// ----------------------------------------------------------------------------
// cter_replay
// Back end: holds the pattern table and the time state, and walks due
// entries one at a time on each tick.
// ----------------------------------------------------------------------------
module cter_replay (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        source_id,
   input  logic              cmd_valid,
   input  cter_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_push,
   output cter_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);

   logic [cter_pkg::TIME_W-1:0]  pattern_mem [cter_pkg::PATTERN_DEPTH];
   logic [cter_pkg::TIME_W-1:0]  rd_data_ff;
   logic                         mem_we;

   cter_pkg::replay_state_type   state_ff, state_in;
   logic [cter_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [cter_pkg::IDX_W-1:0]   pos_ff, pos_in;
   logic [cter_pkg::NCNT_W-1:0]  n_ff, n_in;
   logic                         recorded_ff, recorded_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [cter_pkg::TIME_W-1:0]  cycle_start_ff, cycle_start_in;
   logic [cter_pkg::TIME_W-1:0]  current_time_ff, current_time_in;
   logic [cter_pkg::TIME_W-1:0]  last_off_ff, last_off_in;
   logic [cter_pkg::TIME_W-1:0]  elapsed_ff, elapsed_in;
   cter_pkg::rsp_type            pend_ff, pend_in;
   logic [cter_pkg::CNT_W-1:0]   pos_next;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      n_in            = n_ff;
      recorded_in     = recorded_ff;
      pend_valid_in   = pend_valid_ff;
      cycle_start_in  = cycle_start_ff;
      current_time_in = current_time_ff;
      last_off_in     = last_off_ff;
      elapsed_in      = elapsed_ff;
      pend_in         = pend_ff;
      cmd_pop         = 1'b0;
      rsp_push        = 1'b0;
      mem_we          = 1'b0;
      rsp_data        = pend_ff;
      rsp_data.last   = state_ff == cter_pkg::ST_FLUSH;
      pos_next        = cter_pkg::CNT_W'(pos_ff) + 1'b1;

      case (state_ff)
         cter_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  cter_pkg::OP_APPEND: begin
                     // full table: ignore the append
                     if (count_ff < cter_pkg::CNT_W'(cter_pkg::PATTERN_DEPTH)) begin
                        mem_we      = 1'b1;
                        count_in    = count_ff + 1'b1;
                        last_off_in = cmd_data.value;
                     end
                  end
                  cter_pkg::OP_SET_TIME: begin
                     current_time_in = cmd_data.value;
                  end
                  cter_pkg::OP_TICK: begin
                     if (count_ff != '0) begin
                        if (!recorded_ff) begin
                           cycle_start_in = current_time_ff;
                           recorded_in    = 1'b1;
                        end else begin
                           n_in     = '0;
                           state_in = cter_pkg::ST_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         cter_pkg::ST_READ: begin
            elapsed_in = current_time_ff - cycle_start_ff;
            state_in   = cter_pkg::ST_COMPARE;
         end

         cter_pkg::ST_COMPARE: begin
            if (elapsed_ff > rd_data_ff) begin
               // hold while the previous result cannot be handed off
               if (!(pend_valid_ff && rsp_full)) begin
                  rsp_push              = pend_valid_ff;
                  pend_in.out_source    = source_id;
                  pend_in.entry_index   = 6'(pos_ff);
                  pend_in.event_time    = cycle_start_ff + rd_data_ff;
                  pend_in.last          = 1'b0;
                  pend_valid_in         = 1'b1;
                  n_in                  = n_ff + 1'b1;
                  if (pos_next >= count_ff) begin
                     pos_in         = '0;
                     cycle_start_in = cycle_start_ff + last_off_ff;
                  end else begin
                     pos_in = pos_next[cter_pkg::IDX_W-1:0];
                  end
                  state_in = (n_ff == cter_pkg::NCNT_W'(cter_pkg::MAX_PER_TICK - 1)) ?
                             cter_pkg::ST_FLUSH : cter_pkg::ST_READ;
               end
            end else begin
               state_in = pend_valid_ff ? cter_pkg::ST_FLUSH : cter_pkg::ST_IDLE;
            end
         end

         cter_pkg::ST_FLUSH: begin
            // final result of the tick carries the last flag
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = cter_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cter_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cter_pkg::ST_IDLE;
         count_ff        <= '0;
         pos_ff          <= '0;
         n_ff            <= '0;
         recorded_ff     <= 1'b0;
         pend_valid_ff   <= 1'b0;
         cycle_start_ff  <= '0;
         current_time_ff <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         pos_ff          <= pos_in;
         n_ff            <= n_in;
         recorded_ff     <= recorded_in;
         pend_valid_ff   <= pend_valid_in;
         cycle_start_ff  <= cycle_start_in;
         current_time_ff <= current_time_in;
      end
   end

   always_ff @(posedge clock) begin
      last_off_ff <= last_off_in;
      elapsed_ff  <= elapsed_in;
      pend_ff     <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pattern_mem[count_ff[cter_pkg::IDX_W-1:0]] <= cmd_data.value;
      end
      rd_data_ff <= pattern_mem[pos_ff];
   end

endmodule

// File: rtl/cyclic_timed_event_replay.sv
// ----------------------------------------------------------------------------
// cyclic_timed_event_replay
// An append or time load takes effect when the replay engine pops it from the
// command queue; each result of a tick is held in a pending register before it
// enters the result queue. Throughput: one item per cycle into the command queue
// while it is not full; the engine handles one command at a time, and a tick makes
// one table read and one compare per due entry, up to 16 entries per tick.
// Reset is synchronous; it clears counts, times, source id and both queues.
// ----------------------------------------------------------------------------
module cyclic_timed_event_replay (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  cter_pkg::req_type             req_item,
   output logic                          empty,
   input  logic                          pop,
   output cter_pkg::rsp_type             rsp_item,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cter_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [7:0]        source_id_ff, source_id_in;
   logic              cmd_valid, cmd_pop, rsp_push, rsp_full;
   cter_pkg::cmd_type cmd_data;
   cter_pkg::rsp_type rsp_data;

   assign pready = 1'b1;
   assign prdata = (paddr == cter_pkg::ADDR_SOURCE_ID) ? {24'd0, source_id_ff} : 32'd0;

   always_comb begin
      source_id_in = source_id_ff;
      if (psel && penable && pwrite && (paddr == cter_pkg::ADDR_SOURCE_ID)) begin
         source_id_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_id_ff <= '0;
      end else begin
         source_id_ff <= source_id_in;
      end
   end

   cter_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   cter_replay u_replay (
      .clock     (clock),
      .reset     (reset),
      .source_id (source_id_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full)
   );

   cter_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (rsp_push),
      .wr_data  (rsp_data),
      .wr_full  (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
